>>> hw/rtl/iir_direct_form_two_defines.svh
// Assertion macros for the Direct-Form II IIR filter.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef IIR_DIRECT_FORM_TWO_DEFINES_SVH
`define IIR_DIRECT_FORM_TWO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IIRDF2_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iirdf2: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define IIRDF2_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iirdf2: next-cycle check failed");

`endif

>>> hw/rtl/iirdf2_pkg.sv
// Shared types, constants and saturation helpers for the IIR filter.
// No dependencies.
`default_nettype none

package iirdf2_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int LINE_W   = 24;
  localparam int PROD_W   = COEF_W + LINE_W;   // 40
  localparam int ACC_W    = PROD_W + 3;        // sum of up to eight products
  localparam int RND_SH   = 14;
  localparam int RND_W    = ACC_W - RND_SH;    // 29
  localparam int FRONT_W  = RND_W + 2;         // 31
  localparam int CFG_W    = 64;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_LO  = 3'd0,
    REG_FF_HI  = 3'd1,
    REG_FB_LO  = 3'd2,
    REG_FB_HI  = 3'd3,
    REG_FF_CNT = 3'd4,
    REG_FB_CNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_WAIT,
    ST_FRONT,
    ST_FF,
    ST_FF_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic issue;  // launch one product this cycle
    logic clear;  // zero the accumulator
  } mac_ctrl_t;

  typedef struct packed {
    logic                     clip;
    logic signed [LINE_W-1:0] val;
  } line_sat_t;

  typedef struct packed {
    logic                       clip;
    logic signed [SAMPLE_W-1:0] val;
  } out_sat_t;

  // Saturate the new front entry to 24 bits
  function automatic line_sat_t sat_line(input logic signed [FRONT_W-1:0] v);
    line_sat_t r;
    r.clip = (v[FRONT_W-1:LINE_W-1] != '0) && (v[FRONT_W-1:LINE_W-1] != '1);
    if (r.clip) begin
      r.val = v[FRONT_W-1] ? {1'b1, {(LINE_W-1){1'b0}}} : {1'b0, {(LINE_W-1){1'b1}}};
    end else begin
      r.val = v[LINE_W-1:0];
    end
    return r;
  endfunction

  // Saturate the rounded output to 16 bits
  function automatic out_sat_t sat_out(input logic signed [RND_W-1:0] v);
    out_sat_t r;
    r.clip = (v[RND_W-1:SAMPLE_W-1] != '0) && (v[RND_W-1:SAMPLE_W-1] != '1);
    if (r.clip) begin
      r.val = v[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r.val = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/iirdf2_cfg.sv
// Configuration registers, effective tap counts and coefficient select.
// Depends on iirdf2_pkg.
`default_nettype none

module iirdf2_cfg
  import iirdf2_pkg::*;
#(
  parameter int MAX_TAPS = 8,
  parameter int IDX_W    = 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 sel_ff_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  output logic signed [COEF_W-1:0]  coef_o,
  output logic [IDX_W-1:0]          ff_last_o,
  output logic [IDX_W-1:0]          fb_last_o
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAPS);

  logic [CFG_W-1:0] ff_lo_q, ff_hi_q, fb_lo_q, fb_hi_q;
  logic [CNT_W-1:0] ff_cnt_q, fb_cnt_q;
  logic [2*CFG_W-1:0] bank;
  logic [2:0]       idx3;
  logic [CNT_W-1:0] ff_last4, fb_last4;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_lo_q  <= CFG_W'(16384);
      ff_hi_q  <= '0;
      fb_lo_q  <= '0;
      fb_hi_q  <= '0;
      ff_cnt_q <= CNT_W'(1);
      fb_cnt_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_FF_LO:  ff_lo_q  <= cfg_wdata_i;
        REG_FF_HI:  ff_hi_q  <= cfg_wdata_i;
        REG_FB_LO:  fb_lo_q  <= cfg_wdata_i;
        REG_FB_HI:  fb_hi_q  <= cfg_wdata_i;
        REG_FF_CNT: ff_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        REG_FB_CNT: fb_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to 1..MAX_TAPS and hand back the last tap index
  function automatic logic [CNT_W-1:0] last_tap(input logic [CNT_W-1:0] cnt);
    if (cnt == '0) begin
      return '0;
    end else if (cnt > MAX_CNT) begin
      return MAX_CNT - CNT_W'(1);
    end
    return cnt - CNT_W'(1);
  endfunction

  always_comb begin
    ff_last4 = last_tap(ff_cnt_q);
    fb_last4 = last_tap(fb_cnt_q);
  end

  assign ff_last_o = ff_last4[IDX_W-1:0];
  assign fb_last_o = fb_last4[IDX_W-1:0];

  // Pick one 16-bit coefficient from the selected bank
  assign bank   = sel_ff_i ? {ff_hi_q, ff_lo_q} : {fb_hi_q, fb_lo_q};
  assign idx3   = 3'(idx_i);
  assign coef_o = bank[{idx3, 4'd0} +: COEF_W];

endmodule

`default_nettype wire

>>> hw/rtl/iirdf2_mac.sv
// Shared multiply-accumulate: registered product, then accumulate.
// Depends on iirdf2_pkg.
`default_nettype none

module iirdf2_mac
  import iirdf2_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mac_ctrl_t           ctrl_i,
  input  wire logic signed [COEF_W-1:0] coef_i,
  input  wire logic signed [LINE_W-1:0] data_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;

  assign prod_d = coef_i * data_i;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  // Accumulate stage; clear wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/iir_direct_form_two.sv
// Steps from the accepting edge to a valid result: N-1 feedback products,
// feedback drain, front update, M feedforward products, feedforward drain,
// result load; the feedback products and drain are skipped when N is 1.
// A new sample is accepted only once the sequencer is back in idle; a result stalled
// at the output holds the sequencer in its last step.
// Reset: coefficients b0 = 1.0, all others 0, counts 1, delay line zero, idle.
`default_nettype none
`include "iir_direct_form_two_defines.svh"

module iir_direct_form_two
  import iirdf2_pkg::*;
#(
  parameter int MAX_TAPS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        clipped_o
);

  localparam int IDX_W = $clog2(MAX_TAPS);

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic signed [LINE_W-1:0]   line_q [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       clip_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_clip_q;

  logic                       in_acc;
  logic                       load_out;
  logic                       sel_ff;
  mac_ctrl_t                  mac_ctrl;
  logic signed [COEF_W-1:0]   coef;
  logic [IDX_W-1:0]           ff_last, fb_last;
  logic signed [ACC_W-1:0]    mac_acc;
  logic signed [ACC_W-1:0]    acc_bias;
  logic signed [RND_W-1:0]    acc_rnd;
  logic signed [FRONT_W-1:0]  front_w;
  line_sat_t                  front_sat;
  out_sat_t                   y_sat;

  iirdf2_cfg #(
    .MAX_TAPS (MAX_TAPS),
    .IDX_W    (IDX_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sel_ff_i    (sel_ff),
    .idx_i       (idx_q),
    .coef_o      (coef),
    .ff_last_o   (ff_last),
    .fb_last_o   (fb_last)
  );

  iirdf2_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .data_i (line_q[idx_q]),
    .acc_o  (mac_acc)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Round half up to Q.15, then saturate
  assign acc_bias  = mac_acc + ACC_W'(8192);
  assign acc_rnd   = acc_bias[ACC_W-1:RND_SH];
  assign front_w   = FRONT_W'(sample_q) - FRONT_W'(acc_rnd);
  assign front_sat = sat_line(front_w);
  assign y_sat     = sat_out(acc_rnd);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Sequence feedback taps, front update, feedforward taps, result load
  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clear = 1'b0;
    sel_ff         = 1'b0;
    load_out       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mac_ctrl.clear = 1'b1;
          idx_d          = IDX_W'(1);
          state_d        = (fb_last == '0) ? ST_FRONT : ST_FB;
        end
      end
      ST_FB: begin
        mac_ctrl.issue = 1'b1;
        if (idx_q == fb_last) begin
          state_d = ST_FB_WAIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_FB_WAIT: begin
        state_d = ST_FRONT;
      end
      ST_FRONT: begin
        mac_ctrl.clear = 1'b1;
        idx_d          = '0;
        state_d        = ST_FF;
      end
      ST_FF: begin
        mac_ctrl.issue = 1'b1;
        sel_ff         = 1'b1;
        if (idx_q == ff_last) begin
          state_d = ST_FF_WAIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_FF_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Delay line: shift on accept, write the saturated front entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        line_q[k] <= '0;
      end
    end else if (in_acc) begin
      for (int k = 1; k < MAX_TAPS; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end else if (state_q == ST_FRONT) begin
      line_q[0] <= front_sat.val;
    end
  end

  // Capture the sample
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_in_i;
    end
  end

  // Track saturation across the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (in_acc) begin
      clip_q <= 1'b0;
    end else if (state_q == ST_FRONT) begin
      clip_q <= front_sat.clip;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sample_q <= y_sat.val;
      out_clip_q   <= clip_q | y_sat.clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

  // Checks
  `IIRDF2_ASSERT_IMP(a_fb_idx_range, state_q == ST_FB, idx_q != '0 && idx_q <= fb_last)
  `IIRDF2_ASSERT_NXT(a_hold_finish, state_q == ST_FINISH && out_valid_q && out_stall_i, state_q == ST_FINISH)
  `IIRDF2_ASSERT_NXT(a_accept_clears, in_acc, !clip_q && mac_acc == '0)
  `IIRDF2_ASSERT_IMP(a_front_order, state_q == ST_FRONT, $past(state_q) == ST_FB_WAIT || $past(state_q) == ST_IDLE)

endmodule

`default_nettype wire
